// File: rtl/core/lzw_stream_compressor_assert.svh
// assertion macros for the lzw stream compressor checker
// no dependencies; included by the checker file
`ifndef LZW_STREAM_COMPRESSOR_ASSERT_SVH
`define LZW_STREAM_COMPRESSOR_ASSERT_SVH

// same-cycle implication
`define LZWSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzw stream compressor assertion failed");

// next-cycle implication
`define LZWSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzw stream compressor assertion failed");

`endif

// File: rtl/core/lzwsc_pkg.sv
// shared constants, types and helper functions of the lzw stream compressor
// no dependencies; used by every other file except lzwsc_ram and the assertion header
`timescale 1ns / 1ps

package lzwsc_pkg;

   localparam int MAX_CODES     = 4096;
   localparam int CODE_W        = $clog2(MAX_CODES);
   localparam int LIMIT_W       = CODE_W + 1;
   localparam int BYTE_W        = 8;
   localparam int KEY_W         = CODE_W + BYTE_W;
   localparam int HASH_DEPTH    = 2 * MAX_CODES;
   localparam int HASH_W        = $clog2(HASH_DEPTH);
   localparam int EPOCH_W       = 8;
   localparam int FIRST_CODE    = 256;
   localparam int MIN_CODE_BITS = 9;
   localparam int CBITS_W       = 4;
   localparam int COUNT_W       = 32;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic               end_of_stream;
      logic [CBITS_W-1:0] code_bits;
      logic [COUNT_W-1:0] bytes_in_total;
      logic [COUNT_W-1:0] codes_out_total;
   } rsp_item_type;

   typedef struct packed {
      logic         push;
      rsp_item_type item;
   } rsp_push_type;

   typedef struct packed {
      logic               live;
      logic [EPOCH_W-1:0] epoch;
      logic [KEY_W-1:0]   key;
      logic [CODE_W-1:0]  code;
   } slot_type;

   localparam int ENTRY_W = $bits(slot_type);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_FINAL
   } state_type;

   function automatic logic [HASH_W-1:0] hash_slot(input logic [CODE_W-1:0] prefix,
                                                    input logic [BYTE_W-1:0] data);
      return HASH_W'(prefix) ^ (HASH_W'(data) << (HASH_W - BYTE_W));
   endfunction

   function automatic logic [CBITS_W-1:0] code_width(input logic [LIMIT_W-1:0] n);
      logic [CBITS_W-1:0] w;
      w = CBITS_W'(MIN_CODE_BITS);
      for (int b = MIN_CODE_BITS + 1; b <= CODE_W + 1; b++) begin
         if (n > LIMIT_W'(1 << (b - 2))) begin
            w = CBITS_W'(b);
         end
      end
      return w;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
      logic [LIMIT_W-1:0] r;
      r = v;
      if (v < LIMIT_W'(FIRST_CODE)) begin
         r = LIMIT_W'(FIRST_CODE);
      end else if (v > LIMIT_W'(MAX_CODES)) begin
         r = LIMIT_W'(MAX_CODES);
      end
      return r;
   endfunction

endpackage

// File: rtl/core/lzwsc_ifs.sv
// valid/ready channel interfaces: byte input, code output, limit register write
// depends on lzwsc_pkg
`timescale 1ns / 1ps

interface lzwsc_req_if;
   import lzwsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzwsc_rsp_if;
   import lzwsc_pkg::*;
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  code;
   logic               end_of_stream;
   logic [CBITS_W-1:0] code_bits;
   logic [COUNT_W-1:0] bytes_in_total;
   logic [COUNT_W-1:0] codes_out_total;
   modport source (output valid, output code, output end_of_stream, output code_bits,
                   output bytes_in_total, output codes_out_total, input ready);
   modport sink (input valid, input code, input end_of_stream, input code_bits,
                 input bytes_in_total, input codes_out_total, output ready);
endinterface

interface lzwsc_csr_if;
   import lzwsc_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] dict_limit;
   modport source (output valid, output dict_limit, input ready);
   modport sink (input valid, input dict_limit, output ready);
endinterface

// File: rtl/core/lzw_stream_compressor.sv
// lzw stream compressor top level: limit register, dictionary sequencer, result queue
// depends on lzwsc_pkg, lzwsc_ifs, lzwsc_ctrl, lzwsc_out_fifo
//
//   channel   direction  payload                                             transfer when
//   req_bus   in         data_byte, last_byte                                valid & ready
//   rsp_bus   out        code, end_of_stream, code_bits, bytes_in_total,     valid & ready
//                        codes_out_total
//   csr_bus   in         dict_limit (clamped to 256..4096)                   valid & ready
//
// a byte issues the dictionary ram read in S_IDLE, then S_PROBE compares the registered
// read data; each occupied slot that does not match adds another probe read in S_PROBE.
// a message's first byte only sets the prefix; a final byte adds S_FINAL for the last code.
// after reset, and after every 256th message, the 8192-slot ram is swept slot by slot
// with req_bus.ready low. req_bus.ready also drops while the result queue has < 2 free slots.
`timescale 1ns / 1ps

module lzw_stream_compressor (
   input  logic        clock,
   input  logic        reset,
   lzwsc_req_if.sink   req_bus,
   lzwsc_rsp_if.source rsp_bus,
   lzwsc_csr_if.sink   csr_bus
);
   import lzwsc_pkg::*;

   logic [LIMIT_W-1:0] dict_limit_ff, dict_limit_in;
   rsp_push_type       push;
   logic               room_two;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      dict_limit_in = dict_limit_ff;
      if (csr_bus.valid) begin
         dict_limit_in = clamp_limit(csr_bus.dict_limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_limit_ff <= LIMIT_W'(MAX_CODES);
      end else begin
         dict_limit_ff <= dict_limit_in;
      end
   end

   lzwsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .dict_limit (dict_limit_ff),
      .room_two   (room_two),
      .push_out   (push)
   );

   lzwsc_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .room_two (room_two),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: rtl/core/lzwsc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module lzwsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lzwsc_out_fifo.sv
// four-entry result queue between the dictionary sequencer and the output channel
// depends on lzwsc_pkg and lzwsc_ifs
`timescale 1ns / 1ps

module lzwsc_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  lzwsc_pkg::rsp_push_type push_in,
   output logic                  room_two,
   lzwsc_rsp_if.source           rsp_bus
);
   import lzwsc_pkg::*;

   rsp_item_type       slots_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff, count_in;
   logic               pop;
   rsp_item_type       head;

   always_comb begin
      head      = slots_ff[rd_ptr_ff];
      pop       = rsp_bus.valid && rsp_bus.ready;
      wr_ptr_in = push_in.push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW + 1)'(push_in.push) - (FIFO_AW + 1)'(pop);
      room_two  = count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slots_ff[wr_ptr_ff] <= push_in.item;
      end
   end

   assign rsp_bus.valid           = count_ff != '0;
   assign rsp_bus.code            = head.code;
   assign rsp_bus.end_of_stream   = head.end_of_stream;
   assign rsp_bus.code_bits       = head.code_bits;
   assign rsp_bus.bytes_in_total  = head.bytes_in_total;
   assign rsp_bus.codes_out_total = head.codes_out_total;

endmodule

// File: rtl/core/lzwsc_ctrl.sv
// dictionary sequencer: hashed lookup with linear probing in one ram, epoch-tagged
// entries, message counters and result generation; depends on lzwsc_pkg, lzwsc_ifs, lzwsc_ram
`timescale 1ns / 1ps

module lzwsc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   lzwsc_req_if.sink                  req_bus,
   input  logic [lzwsc_pkg::LIMIT_W-1:0] dict_limit,
   input  logic                       room_two,
   output lzwsc_pkg::rsp_push_type    push_out
);
   import lzwsc_pkg::*;

   state_type          state_ff, state_in;
   logic [CODE_W-1:0]  prefix_ff, prefix_in;
   logic               present_ff, present_in;
   logic [LIMIT_W-1:0] next_free_ff, next_free_in;
   logic [COUNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [COUNT_W-1:0] code_cnt_ff, code_cnt_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [HASH_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;
   logic [HASH_W-1:0]  slot_ff, slot_in;

   logic               ram_wr_en;
   logic [HASH_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [HASH_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   slot_type           rd_slot;
   slot_type           new_slot;
   logic [KEY_W-1:0]   key;
   logic               accept;
   logic [HASH_W-1:0]  first_slot;

   lzwsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (HASH_DEPTH)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         prefix_ff    <= '0;
         present_ff   <= 1'b0;
         next_free_ff <= LIMIT_W'(FIRST_CODE);
         byte_cnt_ff  <= '0;
         code_cnt_ff  <= '0;
         epoch_ff     <= '0;
         clr_addr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         present_ff   <= present_in;
         next_free_ff <= next_free_in;
         byte_cnt_ff  <= byte_cnt_in;
         code_cnt_ff  <= code_cnt_in;
         epoch_ff     <= epoch_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      slot_ff <= slot_in;
   end

   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      present_in   = present_ff;
      next_free_in = next_free_ff;
      byte_cnt_in  = byte_cnt_ff;
      code_cnt_in  = code_cnt_ff;
      epoch_in     = epoch_ff;
      clr_addr_in  = clr_addr_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;

      rd_slot      = slot_type'(ram_rd_data);
      key          = {prefix_ff, byte_ff};
      new_slot     = '{live: 1'b1, epoch: epoch_ff, key: key,
                       code: next_free_ff[CODE_W-1:0]};
      first_slot   = hash_slot(prefix_ff, req_bus.data_byte);

      req_bus.ready = 1'b0;
      accept        = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = ENTRY_W'(new_slot);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = slot_ff;
      push_out      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep every slot to empty
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + HASH_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_bus.ready = room_two;
            accept        = req_bus.valid && room_two;
            if (accept) begin
               byte_in     = req_bus.data_byte;
               last_in     = req_bus.last_byte;
               byte_cnt_in = sat_inc(byte_cnt_ff);
               if (!present_ff) begin
                  prefix_in  = CODE_W'(req_bus.data_byte);
                  present_in = 1'b1;
                  state_in   = req_bus.last_byte ? S_FINAL : S_IDLE;
               end else begin
                  slot_in     = first_slot;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = first_slot;
                  state_in    = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (rd_slot.live && rd_slot.epoch == epoch_ff) begin
               if (rd_slot.key == key) begin
                  prefix_in = rd_slot.code;
                  state_in  = last_ff ? S_FINAL : S_IDLE;
               end else begin
                  // occupied by another pair: try the next slot
                  slot_in     = slot_ff + HASH_W'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = slot_ff + HASH_W'(1);
               end
            end else begin
               push_out.push      = 1'b1;
               push_out.item.code = prefix_ff;
               code_cnt_in        = sat_inc(code_cnt_ff);
               if (next_free_ff < dict_limit) begin
                  ram_wr_en    = 1'b1;
                  next_free_in = next_free_ff + LIMIT_W'(1);
               end
               prefix_in = CODE_W'(byte_ff);
               state_in  = last_ff ? S_FINAL : S_IDLE;
            end
         end
         S_FINAL: begin
            push_out.push                 = 1'b1;
            push_out.item.code            = prefix_ff;
            push_out.item.end_of_stream   = 1'b1;
            push_out.item.code_bits       = code_width(next_free_ff);
            push_out.item.bytes_in_total  = byte_cnt_ff;
            push_out.item.codes_out_total = sat_inc(code_cnt_ff);
            prefix_in    = '0;
            present_in   = 1'b0;
            next_free_in = LIMIT_W'(FIRST_CODE);
            byte_cnt_in  = '0;
            code_cnt_in  = '0;
            epoch_in     = epoch_ff + EPOCH_W'(1);
            // epoch wrap: old tags would alias, so sweep the table
            state_in     = (epoch_ff == '1) ? S_CLEAR : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/lzwsc_checker.sv
// port-level checks of the lzw stream compressor, bound to the top level
// depends on lzwsc_pkg and lzw_stream_compressor_assert.svh
`timescale 1ns / 1ps
`include "lzw_stream_compressor_assert.svh"

module lzwsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lzwsc_pkg::CODE_W-1:0]  rsp_code,
   input logic                          rsp_eos,
   input logic [lzwsc_pkg::CBITS_W-1:0] rsp_code_bits,
   input logic [lzwsc_pkg::COUNT_W-1:0] rsp_bytes,
   input logic [lzwsc_pkg::COUNT_W-1:0] rsp_codes
);
   import lzwsc_pkg::*;

   logic req_seen;
   assign req_seen = req_valid || req_ready;

   // reset leaves the queue empty and starts the table sweep
   `LZWSC_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready)

   // only the final code of a message carries width and counts
   `LZWSC_ASSERT_IMP(a_mid_fields_zero, clock, reset, rsp_valid && !rsp_eos, rsp_code_bits == '0 && rsp_bytes == '0 && rsp_codes == '0)

   `LZWSC_ASSERT_IMP(a_final_fields, clock, reset, rsp_valid && rsp_eos && req_seen | !req_seen && rsp_valid && rsp_eos, rsp_code_bits >= CBITS_W'(MIN_CODE_BITS) && rsp_code_bits <= CBITS_W'(CODE_W + 1) && rsp_bytes != '0 && rsp_codes != '0)

   `LZWSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code) && $stable(rsp_eos))

endmodule

bind lzw_stream_compressor lzwsc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_code      (rsp_bus.code),
   .rsp_eos       (rsp_bus.end_of_stream),
   .rsp_code_bits (rsp_bus.code_bits),
   .rsp_bytes     (rsp_bus.bytes_in_total),
   .rsp_codes     (rsp_bus.codes_out_total)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for lzw_stream_compressor, with a code predictor
// and paced channels; depends on lzwsc_pkg, lzwsc_ifs and the compressor rtl

module tb_top;
   import lzwsc_pkg::*;

   localparam int QUIET_CYCLES   = 32;
   localparam int HOLD_CYCLES    = 300;
   localparam int TOTAL_BYTES    = 850;
   localparam int SHORT_MSG_GOAL = 270;
   localparam int LONG_MSG_LEN   = 280;
   localparam int MAX_REPORTS    = 200;
   localparam int LIMIT_TOP      = (1 << LIMIT_W) - 1;

   typedef enum bit {ROW_BYTE, ROW_LIMIT} row_kind_type;
   typedef enum logic [1:0] {STYLE_FEW, STYLE_ANY, STYLE_RUNS} msg_style_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_type;

   typedef struct {
      row_kind_type       kind;
      bit [LIMIT_W-1:0]   value;
      bit                 is_last;
      bit                 typed;
      rsp_item_type       fin;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzwsc_req_if req_bus();
   lzwsc_rsp_if rsp_bus();
   lzwsc_csr_if csr_bus();

   lzw_stream_compressor uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // predictor state
   bit [CODE_W-1:0]  learned [bit [KEY_W-1:0]];
   bit [CODE_W-1:0]  cur_prefix = '0;
   bit               have_prefix = 1'b0;
   int unsigned      next_code = FIRST_CODE;
   bit [COUNT_W-1:0] msg_bytes = '0;
   bit [COUNT_W-1:0] msg_codes = '0;
   int unsigned      limit_shadow = MAX_CODES;

   rsp_item_type awaited_codes[$];
   stim_row_type stim_table[$];

   int unsigned errors = 0;
   int unsigned codes_checked = 0;
   int unsigned bytes_sent = 0;
   int unsigned msgs_sent = 0;
   int unsigned limit_writes = 0;
   int unsigned burst_left = 0;
   int unsigned burst_gap = 0;
   bit          gapless = 1'b0;
   bit          hold_request = 1'b0;

   function automatic bit [COUNT_W-1:0] count_up(input bit [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   function automatic bit [CBITS_W-1:0] packing_width(input int unsigned n);
      int unsigned bits;
      int unsigned span;
      bits = 1;
      span = 1;
      while (span < n) begin
         span = span << 1;
         bits++;
      end
      if (bits < MIN_CODE_BITS) begin
         bits = MIN_CODE_BITS;
      end
      return bits[CBITS_W-1:0];
   endfunction

   function automatic int unsigned fit_limit(input bit [LIMIT_W-1:0] v);
      int unsigned r;
      r = 32'(v);
      if (r < FIRST_CODE) begin
         r = FIRST_CODE;
      end else if (r > MAX_CODES) begin
         r = MAX_CODES;
      end
      return r;
   endfunction

   function automatic void compress_byte(input bit [BYTE_W-1:0] b, input bit is_last);
      rsp_item_type     r;
      bit [KEY_W-1:0]   key;
      r = '0;
      msg_bytes = count_up(msg_bytes);
      if (!have_prefix) begin
         cur_prefix = CODE_W'(b);
         have_prefix = 1'b1;
      end else begin
         key = {cur_prefix, b};
         if (learned.exists(key)) begin
            cur_prefix = learned[key];
         end else begin
            msg_codes = count_up(msg_codes);
            r.code = cur_prefix;
            awaited_codes.push_back(r);
            if (next_code < limit_shadow && next_code < MAX_CODES) begin
               learned[key] = next_code[CODE_W-1:0];
               next_code++;
            end
            cur_prefix = CODE_W'(b);
         end
      end
      if (is_last) begin
         msg_codes = count_up(msg_codes);
         r.code = cur_prefix;
         r.end_of_stream = 1'b1;
         r.code_bits = packing_width(next_code);
         r.bytes_in_total = msg_bytes;
         r.codes_out_total = msg_codes;
         awaited_codes.push_back(r);
         learned.delete();
         cur_prefix = '0;
         have_prefix = 1'b0;
         next_code = FIRST_CODE;
         msg_bytes = '0;
         msg_codes = '0;
      end
   endfunction

   task automatic report(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [COUNT_W-1:0] got,
                                input logic [COUNT_W-1:0] want);
      if (got !== want) begin
         report($sformatf("code #%0d %s: got %0d, expected %0d",
                          codes_checked, name, got, want));
      end
   endtask

   task automatic check_code();
      rsp_item_type want;
      if (awaited_codes.size() == 0) begin
         report($sformatf("code %0d arrived with nothing expected", rsp_bus.code));
      end else begin
         want = awaited_codes.pop_front();
         compare_field("code", COUNT_W'(rsp_bus.code), COUNT_W'(want.code));
         compare_field("end_of_stream", COUNT_W'(rsp_bus.end_of_stream),
                       COUNT_W'(want.end_of_stream));
         compare_field("code_bits", COUNT_W'(rsp_bus.code_bits), COUNT_W'(want.code_bits));
         compare_field("bytes_in_total", rsp_bus.bytes_in_total, want.bytes_in_total);
         compare_field("codes_out_total", rsp_bus.codes_out_total, want.codes_out_total);
         codes_checked++;
      end
   endtask

   function automatic int unsigned next_gap();
      if (gapless) begin
         return 0;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         burst_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         return burst_gap;
      end
      burst_left--;
      return 0;
   endfunction

   function automatic msg_style_type pick_style();
      return msg_style_type'($urandom_range(0, 2));
   endfunction

   task automatic send_byte(input bit [BYTE_W-1:0] b, input bit is_last, input bit typed,
                            input rsp_item_type fin);
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      compress_byte(b, is_last);
      if (typed) begin
         void'(awaited_codes.pop_back());
         awaited_codes.push_back(fin);
      end
      bytes_sent++;
      if (is_last) begin
         msgs_sent++;
      end
      gap = next_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // idle the input and wait until every code has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited_codes.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input bit [LIMIT_W-1:0] v);
      settle();
      csr_bus.valid <= 1'b1;
      csr_bus.dict_limit <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      limit_shadow = fit_limit(v);
      limit_writes++;
   endtask

   task automatic send_message(input int unsigned len, input msg_style_type style);
      bit [BYTE_W-1:0] b;
      bit [BYTE_W-1:0] base;
      int unsigned     i;
      base = 8'($urandom_range(0, 255));
      b = base;
      for (i = 0; i < len; i++) begin
         if (!gapless && len >= 8 && len <= 100 && i == len / 2 &&
             $urandom_range(0, 7) == 0) begin
            write_limit(LIMIT_W'($urandom_range(FIRST_CODE, next_code + 8)));
         end
         case (style)
            STYLE_FEW: begin
               b = base + 8'($urandom_range(0, 3));
            end
            STYLE_ANY: begin
               b = 8'($urandom_range(0, 255));
            end
            default: begin
               if (i == 0 || $urandom_range(0, 3) == 0) begin
                  b = 8'($urandom_range(0, 255));
               end
            end
         endcase
         send_byte(b, i == len - 1, 1'b0, '0);
      end
   endtask

   function automatic void add_byte(input bit [BYTE_W-1:0] v, input bit is_last);
      stim_row_type row;
      row.kind = ROW_BYTE;
      row.value = LIMIT_W'(v);
      row.is_last = is_last;
      row.typed = 1'b0;
      row.fin = '0;
      stim_table.push_back(row);
   endfunction

   function automatic void add_final(input bit [BYTE_W-1:0] v, input bit [CODE_W-1:0] c,
                                     input bit [CBITS_W-1:0] bits, input int unsigned nb,
                                     input int unsigned nc);
      stim_row_type row;
      row.kind = ROW_BYTE;
      row.value = LIMIT_W'(v);
      row.is_last = 1'b1;
      row.typed = 1'b1;
      row.fin = '0;
      row.fin.code = c;
      row.fin.end_of_stream = 1'b1;
      row.fin.code_bits = bits;
      row.fin.bytes_in_total = nb;
      row.fin.codes_out_total = nc;
      stim_table.push_back(row);
   endfunction

   function automatic void add_limit(input bit [LIMIT_W-1:0] v);
      stim_row_type row;
      row.kind = ROW_LIMIT;
      row.value = v;
      row.is_last = 1'b0;
      row.typed = 1'b0;
      row.fin = '0;
      stim_table.push_back(row);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_code();
      end
   end

   // output pacing, with a long hold-off on request
   initial begin : rx_pacing
      rx_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned stall_left;
      int unsigned tick;
      logic        rdy;
      mode = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      stall_left = 0;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
               RX_OPEN: begin
                  rdy = 1'b1;
               end
               RX_COIN: begin
                  rdy = 1'($urandom_range(0, 1));
               end
               RX_PERIODIC: begin
                  rdy = (tick % 3) == 0;
               end
               default: begin
                  if (stall_left != 0) begin
                     stall_left--;
                     rdy = 1'b0;
                  end else if ($urandom_range(0, 15) == 0) begin
                     stall_left = $urandom_range(4, 20);
                     rdy = 1'b0;
                  end else begin
                     rdy = 1'b1;
                  end
               end
            endcase
         end
         rsp_bus.ready <= rdy;
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int unsigned len;
      int unsigned roll;
      bit          long_done;
      bit          hold_done;
      bit          short_done;
      long_done = 1'b0;
      hold_done = 1'b0;
      short_done = 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.dict_limit <= '0;

      add_final(8'h00, 12'h000, 4'd9, 1, 1);
      add_final(8'hFF, 12'h0FF, 4'd9, 1, 1);
      add_byte(8'h55, 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h55, 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h55, 1'b1);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b1);
      add_byte(8'h01, 1'b0);
      add_final(8'hFE, 12'h0FE, 4'd10, 2, 2);
      // below the floor: no learning at all
      add_limit('0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h80, 1'b0);
      add_final(8'h80, 12'h080, 4'd9, 4, 4);
      add_limit(LIMIT_W'(LIMIT_TOP));
      add_byte(8'h10, 1'b0);
      add_byte(8'h11, 1'b0);
      add_byte(8'h10, 1'b0);
      add_byte(8'h11, 1'b0);
      // limit dropped under next_code in the middle of a message
      add_limit(LIMIT_W'(FIRST_CODE));
      add_byte(8'h10, 1'b0);
      add_byte(8'h11, 1'b0);
      add_byte(8'h10, 1'b1);
      add_limit(LIMIT_W'(MAX_CODES));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) begin
         if (stim_table[k].kind == ROW_LIMIT) begin
            write_limit(stim_table[k].value);
         end else begin
            send_byte(stim_table[k].value[BYTE_W-1:0], stim_table[k].is_last,
                      stim_table[k].typed, stim_table[k].fin);
         end
      end

      while (bytes_sent < TOTAL_BYTES) begin
         case ($urandom_range(0, 15))
            0: begin
               write_limit(LIMIT_W'(FIRST_CODE));
            end
            1: begin
               write_limit(LIMIT_W'($urandom_range(FIRST_CODE + 1, FIRST_CODE + 8)));
            end
            2: begin
               write_limit(LIMIT_W'($urandom_range(300, 600)));
            end
            3: begin
               write_limit(LIMIT_W'(MAX_CODES));
            end
            4: begin
               write_limit(LIMIT_W'($urandom_range(0, LIMIT_TOP)));
            end
            5: begin
               write_limit(LIMIT_W'($urandom_range(0, FIRST_CODE - 1)));
            end
            6: begin
               write_limit(LIMIT_W'($urandom_range(MAX_CODES + 1, LIMIT_TOP)));
            end
            default: begin
            end
         endcase
         if (!long_done && msgs_sent >= 12) begin
            write_limit(LIMIT_W'(MAX_CODES));
            send_message(LONG_MSG_LEN, STYLE_ANY);
            long_done = 1'b1;
         end else if (!hold_done && msgs_sent >= 16) begin
            settle();
            hold_request = 1'b1;
            gapless = 1'b1;
            send_message(48, STYLE_FEW);
            gapless = 1'b0;
            settle();
            hold_done = 1'b1;
         end else if (!short_done && msgs_sent >= 20) begin
            // enough messages to roll the dictionary epoch over
            while (msgs_sent < SHORT_MSG_GOAL) begin
               send_message(($urandom_range(0, 3) == 0) ? 2 : 1, pick_style());
            end
            short_done = 1'b1;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               roll = $urandom_range(0, 19);
               len = (roll < 14) ? $urandom_range(1, 12) :
                     (roll < 19) ? $urandom_range(13, 40) : $urandom_range(41, 100);
               send_message(len, pick_style());
            end
         end
      end

      settle();
      $display("run covered %0d bytes in %0d messages, %0d codes checked, %0d limit writes",
               bytes_sent, msgs_sent, codes_checked, limit_writes);
      $display("mismatches found: %0d", errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
